// File: rtl/floor_ceiling_texel_caster_top_assert.svh
// Assertion macros used by the floor and ceiling texel caster RTL.
`ifndef FLOOR_CEILING_TEXEL_CASTER_TOP_ASSERT_SVH
`define FLOOR_CEILING_TEXEL_CASTER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FCTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after its antecedent.
`define FCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fctc_pkg.sv
// Package with constants and types of the floor and ceiling texel caster.
package fctc_pkg;

  localparam int SCREEN_H  = 768;
  localparam int TEX_SIZE  = 350;
  localparam int ONE_Q16   = 65536;

  // Divider layout: 16 quotient bits, two bits per stage.
  localparam int DIV_BITS  = 16;
  localparam int DIV_PER   = 2;
  localparam int DIV_ST    = DIV_BITS / DIV_PER;
  localparam int NST       = DIV_ST + 6;

  localparam int NUM_W     = 42;
  localparam int DEN_W     = 34;
  localparam int CMP_W     = DEN_W + DIV_BITS;

  // Numerator SCREEN_H * 2^32 and the saturation limit SCREEN_H * 2^16.
  localparam logic [NUM_W-1:0] DIV_NUM = NUM_W'(SCREEN_H) << 32;
  localparam logic [DEN_W-1:0] SAT_LIM = DEN_W'(SCREEN_H) << 16;

  // Reciprocal of the texture size for the modulo.
  localparam int RECIP_SH  = 24;
  localparam logic [15:0] TEX_RECIP = 16'((64'd1 << RECIP_SH) / TEX_SIZE);

  localparam logic [1:0] APB_PLAYER_X = 2'd0;
  localparam logic [1:0] APB_PLAYER_Y = 2'd1;

  typedef enum logic [1:0] {
    ROW_ABOVE   = 2'd0,
    ROW_HORIZON = 2'd1,
    ROW_BELOW   = 2'd2
  } row_kind_t;

  // Per-item payload carried down the pipeline.
  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [22:0] hx;
    logic [22:0] hy;
    row_kind_t   kind;
    logic        sat;
  } pay_t;

endpackage

// File: rtl/floor_ceiling_texel_caster_top.sv
// Floor and ceiling texel caster: column set-up state and a deep row pipeline.
//
//   Channel | Direction | Payload
//   in_     | input     | tuser: func; tdata: column .. row (87 bits in 88)
//   out_    | output    | tdata: out_column, floor_row, ceiling_row, texel_x, texel_y
//   cfg_    | APB slave | player_x at 0x0, player_y at 0x4
//
// One item is taken per cycle while out_tready back-pressure has not filled the pipeline.
// Row requests pass through a 16-step restoring divider, two quotient bits per stage.
// Reset (synchronous, rst_n low) clears all valid bits and initialises the column state.
// Each stage advances when it is empty or the next one advances, so bubbles close up.
// A stalled result holds in the output register while earlier stages keep filling.
module floor_ceiling_texel_caster_top
  import fctc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata fields from bit 0: column, side, ray_x_dir, ray_y_positive, map_x, map_y,
  // wall_frac, perp_dist, draw_end, row; zero pad
  input  logic [87:0] in_tdata,
  // tuser fields: func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata fields from bit 0: out_column, floor_row, ceiling_row, texel_x, texel_y
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "floor_ceiling_texel_caster_top_assert.svh"

  // Input field unpacking.
  logic [9:0]         f_column;
  logic               f_side;
  logic [1:0]         f_xdir;
  logic               f_ypos;
  logic [5:0]         f_mapx;
  logic [5:0]         f_mapy;
  logic [15:0]        f_frac;
  logic [23:0]        f_perp;
  logic signed [10:0] f_dend;
  logic [9:0]         f_row;

  assign f_column = in_tdata[9:0];
  assign f_side   = in_tdata[10];
  assign f_xdir   = in_tdata[12:11];
  assign f_ypos   = in_tdata[13];
  assign f_mapx   = in_tdata[19:14];
  assign f_mapy   = in_tdata[25:20];
  assign f_frac   = in_tdata[41:26];
  assign f_perp   = in_tdata[65:42];
  assign f_dend   = in_tdata[76:66];
  assign f_row    = in_tdata[86:77];

  // Configuration registers.
  logic [21:0] player_x_r;
  logic [21:0] player_y_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
    end else if (cfg_wr) begin
      if ({1'b0, cfg_paddr[2]} == APB_PLAYER_X) player_x_r <= cfg_pwdata[21:0];
      if ({1'b0, cfg_paddr[2]} == APB_PLAYER_Y) player_y_r <= cfg_pwdata[21:0];
    end
  end

  always_comb begin
    if ({1'b0, cfg_paddr[2]} == APB_PLAYER_Y) cfg_prdata = {10'd0, player_y_r};
    else                                       cfg_prdata = {10'd0, player_x_r};
  end

  // Stage enables, rippling back from the output register.
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  logic acc;
  assign acc = in_tvalid && in_tready;

  // Column state written by set-up transactions.
  logic [9:0]  cur_column_r;
  logic [22:0] hit_x_r;
  logic [22:0] hit_y_r;
  logic [23:0] cur_perp_r;
  logic [9:0]  first_row_r;
  logic [22:0] hit_x_nxt;
  logic [22:0] hit_y_nxt;
  logic [22:0] mx;
  logic [22:0] my;

  assign mx = {1'b0, f_mapx, 16'd0};
  assign my = {1'b0, f_mapy, 16'd0};

  always_comb begin
    if (!f_side && f_xdir == 2'd1) begin
      hit_x_nxt = mx;
      hit_y_nxt = my + 23'(f_frac);
    end else if (!f_side && f_xdir == 2'd2) begin
      hit_x_nxt = mx + 23'(ONE_Q16);
      hit_y_nxt = my + 23'(f_frac);
    end else if (f_side && f_ypos) begin
      hit_x_nxt = mx + 23'(f_frac);
      hit_y_nxt = my;
    end else begin
      hit_x_nxt = mx + 23'(f_frac);
      hit_y_nxt = my + 23'(ONE_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_column_r <= '0;
      hit_x_r      <= '0;
      hit_y_r      <= '0;
      cur_perp_r   <= 24'(ONE_Q16);
      first_row_r  <= 10'(SCREEN_H);
    end else if (acc && !in_tuser) begin
      cur_column_r <= f_column;
      hit_x_r      <= hit_x_nxt;
      hit_y_r      <= hit_y_nxt;
      cur_perp_r   <= (f_perp == '0) ? 24'd1 : f_perp;
      if (f_dend[10] || f_dend > 11'sd768) first_row_r <= 10'(SCREEN_H);
      else                                  first_row_r <= f_dend[9:0];
    end
  end

  // Stage 1: range check and row classification.
  logic              row_ok;
  logic signed [11:0] dsig;
  pay_t              s1_p_r;
  logic [9:0]        s1_d_r;
  logic [23:0]       s1_perp_r;

  assign row_ok = (f_row >= first_row_r) && ({1'b0, f_row} < 11'(SCREEN_H));
  assign dsig   = $signed({1'b0, f_row, 1'b0}) - 12'sd768;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_p_r.col  <= cur_column_r;
      s1_p_r.row  <= f_row;
      s1_p_r.hx   <= hit_x_r;
      s1_p_r.hy   <= hit_y_r;
      s1_p_r.sat  <= 1'b0;
      s1_d_r      <= dsig[9:0];
      s1_perp_r   <= cur_perp_r;
      if (dsig == 12'sd0)     s1_p_r.kind <= ROW_HORIZON;
      else if (dsig < 12'sd0) s1_p_r.kind <= ROW_ABOVE;
      else                    s1_p_r.kind <= ROW_BELOW;
    end
  end

  // Stage 2: divisor product and saturation test.
  pay_t             s2_p_r;
  pay_t             s2_p_nxt;
  logic [DEN_W-1:0] s2_den_r;
  logic [DEN_W-1:0] den_nxt;

  assign den_nxt = DEN_W'(s1_d_r) * DEN_W'(s1_perp_r);

  always_comb begin
    s2_p_nxt     = s1_p_r;
    s2_p_nxt.sat = (den_nxt <= SAT_LIM);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_p_r   <= s2_p_nxt;
      s2_den_r <= den_nxt;
    end
  end

  // Stages 3 to 10: restoring divider, two quotient bits per stage.
  pay_t             dv_p_r   [DIV_ST];
  logic [DEN_W-1:0] dv_den_r [DIV_ST];
  logic [NUM_W-1:0] dv_rem_r [DIV_ST];
  logic [15:0]      dv_q_r   [DIV_ST];

  for (genvar g = 0; g < DIV_ST; g++) begin : g_div
    pay_t             p_in;
    logic [DEN_W-1:0] d_in;
    logic [NUM_W-1:0] r_in;
    logic [15:0]      q_in;
    logic [NUM_W-1:0] r_out;
    logic [15:0]      q_out;

    if (g == 0) begin : g_first
      assign p_in = s2_p_r;
      assign d_in = s2_den_r;
      assign r_in = DIV_NUM;
      assign q_in = '0;
    end else begin : g_next
      assign p_in = dv_p_r[g-1];
      assign d_in = dv_den_r[g-1];
      assign r_in = dv_rem_r[g-1];
      assign q_in = dv_q_r[g-1];
    end

    always_comb begin
      logic [CMP_W-1:0] r;
      logic [CMP_W-1:0] c;
      r     = CMP_W'(r_in);
      q_out = q_in;
      for (int k = 0; k < DIV_PER; k++) begin
        c = CMP_W'(d_in) << (DIV_BITS - 1 - (g * DIV_PER + k));
        if (r >= c) begin
          r = r - c;
          q_out[DIV_BITS - 1 - (g * DIV_PER + k)] = 1'b1;
        end
      end
      r_out = r[NUM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[2+g]) begin
        dv_p_r[g]   <= p_in;
        dv_den_r[g] <= d_in;
        dv_rem_r[g] <= r_out;
        dv_q_r[g]   <= q_out;
      end
    end
  end

  // Stage 11: weight selection and blend products.
  pay_t        s11_p_r;
  logic [39:0] s11_ax_r;
  logic [39:0] s11_bx_r;
  logic [39:0] s11_ay_r;
  logic [39:0] s11_by_r;
  logic [16:0] w;
  logic [16:0] wn;
  pay_t        pd;

  assign pd = dv_p_r[DIV_ST-1];

  always_comb begin
    case (pd.kind)
      ROW_ABOVE:   w = '0;
      ROW_HORIZON: w = 17'(ONE_Q16);
      default:     w = pd.sat ? 17'(ONE_Q16) : {1'b0, dv_q_r[DIV_ST-1]};
    endcase
    wn = 17'(ONE_Q16) - w;
  end

  always_ff @(posedge clk) begin
    if (en[DIV_ST+2]) begin
      s11_p_r  <= pd;
      s11_ax_r <= 40'(w) * 40'(pd.hx);
      s11_bx_r <= 40'(wn) * 40'(player_x_r);
      s11_ay_r <= 40'(w) * 40'(pd.hy);
      s11_by_r <= 40'(wn) * 40'(player_y_r);
    end
  end

  // Stage 12: blended floor point scaled by the texture size.
  pay_t        s12_p_r;
  logic [31:0] s12_tx_r;
  logic [31:0] s12_ty_r;
  logic [40:0] sx;
  logic [40:0] sy;

  assign sx = 41'(s11_ax_r) + 41'(s11_bx_r);
  assign sy = 41'(s11_ay_r) + 41'(s11_by_r);

  always_ff @(posedge clk) begin
    if (en[DIV_ST+3]) begin
      s12_p_r  <= s11_p_r;
      s12_tx_r <= 32'(sx[38:16]) * 32'(TEX_SIZE);
      s12_ty_r <= 32'(sy[38:16]) * 32'(TEX_SIZE);
    end
  end

  // Stage 13: reciprocal products for the modulo.
  pay_t        s13_p_r;
  logic [15:0] s13_tx_r;
  logic [15:0] s13_ty_r;
  logic [31:0] s13_mx_r;
  logic [31:0] s13_my_r;

  always_ff @(posedge clk) begin
    if (en[DIV_ST+4]) begin
      s13_p_r  <= s12_p_r;
      s13_tx_r <= s12_tx_r[31:16];
      s13_ty_r <= s12_ty_r[31:16];
      s13_mx_r <= 32'(s12_tx_r[31:16]) * 32'(TEX_RECIP);
      s13_my_r <= 32'(s12_ty_r[31:16]) * 32'(TEX_RECIP);
    end
  end

  // Stage 14: remainder with one correction step, output register.
  logic [15:0] rx;
  logic [15:0] ry;
  logic [15:0] rx_c;
  logic [15:0] ry_c;
  logic [9:0]  o_col_r;
  logic [9:0]  o_row_r;
  logic [9:0]  o_ceil_r;
  logic [8:0]  o_tx_r;
  logic [8:0]  o_ty_r;

  assign rx   = s13_tx_r - 16'(32'(s13_mx_r[31:RECIP_SH]) * 32'(TEX_SIZE));
  assign ry   = s13_ty_r - 16'(32'(s13_my_r[31:RECIP_SH]) * 32'(TEX_SIZE));
  assign rx_c = (rx >= 16'(TEX_SIZE)) ? rx - 16'(TEX_SIZE) : rx;
  assign ry_c = (ry >= 16'(TEX_SIZE)) ? ry - 16'(TEX_SIZE) : ry;

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      o_col_r  <= s13_p_r.col;
      o_row_r  <= s13_p_r.row;
      o_ceil_r <= 10'(11'(SCREEN_H) - 11'(s13_p_r.row));
      o_tx_r   <= rx_c[8:0];
      o_ty_r   <= ry_c[8:0];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= acc && in_tuser && row_ok;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {o_ty_r, o_tx_r, o_ceil_r, o_row_r, o_col_r};

  `FCTC_ASSERT_IMP(a_row_range, v_r[0], s1_p_r.row < 10'(SCREEN_H), "row past screen height")
  `FCTC_ASSERT_IMP(a_texel_x, out_tvalid, o_tx_r < 9'(TEX_SIZE), "texel x not reduced")
  `FCTC_ASSERT_IMP(a_ceiling, out_tvalid,
                   11'(o_ceil_r) + 11'(o_row_r) == 11'(SCREEN_H), "ceiling row mismatch")
  `FCTC_ASSERT_NEXT(a_empty_ready, !v_r[0] && !en[0], 1'b0, "empty entry stage not ready")

endmodule

// File: sim/floor_ceiling_texel_caster_top_test.sv
// Testbench for the floor and ceiling texel caster: directed table, random column runs, checks.
module floor_ceiling_texel_caster_top_test
  import fctc_pkg::*;
();

  localparam int SCR_H = 768;
  localparam int TEX = 350;
  localparam int DRAIN_CYCLES = 40;

  // Result field positions and widths from bit 0.
  localparam int FLD_LO[5] = '{0, 10, 20, 30, 39};
  localparam int FLD_WD[5] = '{10, 10, 10, 9, 9};

  // One input transaction, with an optional typed-in result.
  typedef struct {
    logic        func;
    logic [86:0] data;
    bit          typed;
    logic [47:0] typed_val;
  } stim_t;

  typedef struct {
    bit          valid;
    logic [47:0] val;
  } texel_res_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Typed expectation travelling with the item on the input channel.
  bit          drv_typed = 0;
  logic [47:0] drv_typed_val = '0;

  floor_ceiling_texel_caster_top uut (.*);

  always #1 clk = ~clk;

  // Model state of the block.
  logic [21:0] mdl_player_x, mdl_player_y;
  logic [9:0]  mdl_column;
  logic [22:0] mdl_hit_x, mdl_hit_y;
  logic [23:0] mdl_perp;
  logic [9:0]  mdl_first_row;

  logic [47:0] texel_expq[$];
  stim_t       stimq[$];
  int          errors = 0;
  int          results_seen = 0;
  int          setups_sent = 0;
  int          rows_sent = 0;

  function automatic logic [8:0] texel_of(logic [63:0] coord);
    logic [63:0] t;
    t = (coord * TEX) >> 16;
    return 9'(t % TEX);
  endfunction

  // Apply one accepted transaction to the model and return its result, if any.
  function automatic texel_res_t cast_texel(logic func, logic [86:0] d);
    texel_res_t  r;
    logic [63:0] mx, my, frac, h, twice, w, q, fx, fy;
    logic [10:0] de;
    logic [9:0]  row;
    r.valid = 0;
    r.val = '0;
    h = SCR_H;
    if (!func) begin
      mx = 64'(d[19:14]) << 16;
      my = 64'(d[25:20]) << 16;
      frac = 64'(d[41:26]);
      de = d[76:66];
      mdl_column = d[9:0];
      if (!d[10] && d[12:11] == 2'd1) begin
        mdl_hit_x = 23'(mx);
        mdl_hit_y = 23'(my + frac);
      end else if (!d[10] && d[12:11] == 2'd2) begin
        mdl_hit_x = 23'(mx + 65536);
        mdl_hit_y = 23'(my + frac);
      end else if (d[10] && d[13]) begin
        mdl_hit_x = 23'(mx + frac);
        mdl_hit_y = 23'(my);
      end else begin
        mdl_hit_x = 23'(mx + frac);
        mdl_hit_y = 23'(my + 65536);
      end
      mdl_perp = (d[65:42] == 0) ? 24'd1 : d[65:42];
      mdl_first_row = (de[10] || de > SCR_H) ? 10'(SCR_H) : de[9:0];
      return r;
    end
    row = d[86:77];
    if (row < mdl_first_row || row >= SCR_H) return r;
    twice = 2 * row;
    if (twice == h) w = 65536;
    else if (twice < h) w = 0;
    else begin
      q = (h << 32) / ((twice - h) * mdl_perp);
      w = (q > 65536) ? 64'd65536 : q;
    end
    fx = (w * mdl_hit_x + (65536 - w) * mdl_player_x) >> 16;
    fy = (w * mdl_hit_y + (65536 - w) * mdl_player_y) >> 16;
    r.valid = 1;
    r.val = {texel_of(fy), texel_of(fx), 10'(h - row), row, mdl_column};
    return r;
  endfunction

  function automatic stim_t mk_setup(logic [9:0] col, logic side, logic [1:0] xd, logic yp,
                                     logic [5:0] mx, logic [5:0] my, logic [15:0] frac,
                                     logic [23:0] perp, logic [10:0] de);
    stim_t s;
    s.func = 1'b0;
    s.data = {10'd0, de, perp, frac, my, mx, yp, xd, side, col};
    s.typed = 0;
    s.typed_val = '0;
    return s;
  endfunction

  function automatic stim_t mk_row(logic [9:0] row);
    stim_t s;
    s.func = 1'b1;
    s.data = '0;
    s.data[86:77] = row;
    s.typed = 0;
    s.typed_val = '0;
    return s;
  endfunction

  function automatic stim_t mk_row_exp(logic [9:0] row, logic [47:0] v);
    stim_t s;
    s = mk_row(row);
    s.typed = 1;
    s.typed_val = v;
    return s;
  endfunction

  // Input monitor: predict at every accepted transaction.
  always @(posedge clk) begin
    texel_res_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r = cast_texel(in_tuser, in_tdata[86:0]);
      if (r.valid) texel_expq.push_back(drv_typed ? drv_typed_val : r.val);
    end
  end

  // Output monitor: compare each result field by field with the oldest expectation.
  always @(posedge clk) begin
    logic [47:0] e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (texel_expq.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_tdata);
      end else begin
        e = texel_expq.pop_front();
        for (int f = 0; f < 5; f++) begin
          if (((e >> FLD_LO[f]) & ((48'd1 << FLD_WD[f]) - 1)) !=
              ((out_tdata >> FLD_LO[f]) & ((48'd1 << FLD_WD[f]) - 1))) begin
            errors++;
            $display("%0t: field %0d mismatch, expected %0d, actual %0d", $time, f,
                     (e >> FLD_LO[f]) & ((48'd1 << FLD_WD[f]) - 1),
                     (out_tdata >> FLD_LO[f]) & ((48'd1 << FLD_WD[f]) - 1));
          end
        end
      end
    end
  end

  // Result receiver: random stalls, bursts of full rate, one long hold-off.
  initial begin
    int gap;
    bit burst;
    bit held;
    burst = 0;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1;
        out_tready <= 0;
        for (int c = 0; c < 400; c++) @(posedge clk);
      end
      if ($urandom_range(0, 40) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (addr == 3'(APB_PLAYER_X * 4)) mdl_player_x = value[21:0];
    else mdl_player_y = value[21:0];
  endtask

  // Wait until the block is idle, then set the player position.
  task automatic set_player(logic [21:0] px, logic [21:0] py);
    while (texel_expq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(3'(APB_PLAYER_X * 4), 32'(px));
    write_reg(3'(APB_PLAYER_Y * 4), 32'(py));
  endtask

  task automatic send_items();
    stim_t s;
    int gap;
    bit burst;
    bit active;
    burst = 0;
    active = 0;
    while (stimq.size() != 0) begin
      s = stimq.pop_front();
      if ($urandom_range(0, 30) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0 && active) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end else if (gap > 0) begin
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1;
      in_tuser <= s.func;
      in_tdata <= {1'b0, s.data};
      drv_typed <= s.typed;
      drv_typed_val <= s.typed_val;
      active = 1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (s.func) rows_sent++;
      else setups_sent++;
    end
    in_tvalid <= 0;
  endtask

  // One column run: a random set-up followed by rows, mostly in the floor range.
  task automatic queue_column_run();
    logic [10:0] de;
    logic [23:0] perp;
    int first, n;
    case ($urandom_range(0, 3))
      0: perp = 24'($urandom);
      1: perp = 24'($urandom_range(1, 24'h3FFFF));
      2: perp = 24'($urandom_range(24'h8000, 24'h30000));
      default: perp = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'hFFFFFF;
    endcase
    de = ($urandom_range(0, 9) < 8) ? 11'($urandom_range(0, 767)) : 11'($urandom);
    stimq.push_back(mk_setup(10'($urandom), 1'($urandom), 2'($urandom), 1'($urandom),
                             6'($urandom), 6'($urandom), 16'($urandom), perp, de));
    first = (de[10] || de > 767) ? 0 : de;
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) stimq.push_back(mk_row(10'($urandom_range(first, 767))));
      else stimq.push_back(mk_row(10'($urandom)));
    end
  endtask

  task automatic random_phase(int count);
    int queued;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) begin
        stimq.push_back(mk_row(10'($urandom)));
        queued++;
      end else begin
        queue_column_run();
        queued = stimq.size();
      end
      if (stimq.size() > queued) queued = stimq.size();
    end
    send_items();
  endtask

  // Main sequence: reset, directed table, random phases at several player positions.
  initial begin
    mdl_player_x = 0;
    mdl_player_y = 0;
    mdl_column = 0;
    mdl_hit_x = 0;
    mdl_hit_y = 0;
    mdl_perp = 24'd65536;
    mdl_first_row = 10'(SCR_H);
    repeat (2) @(posedge clk);
    rst_n <= 1;
    set_player(22'd0, 22'd0);

    // Directed table: reset state, extremes, every hit choice and the row special cases.
    stimq.push_back(mk_row(10'd767));
    stimq.push_back(mk_setup(10'd1023, 1'b0, 2'd1, 1'b0, 6'd0, 6'd0, 16'd0, 24'd65536,
                             11'd0));
    stimq.push_back(mk_row_exp(10'd767, {9'd0, 9'd0, 10'd1, 10'd767, 10'd1023}));
    stimq.push_back(mk_row_exp(10'd0, {9'd0, 9'd0, 10'd768, 10'd0, 10'd1023}));
    stimq.push_back(mk_row(10'd384));
    stimq.push_back(mk_row(10'd383));
    stimq.push_back(mk_row(10'd768));
    stimq.push_back(mk_row(10'd1023));
    stimq.push_back(mk_setup(10'd0, 1'b0, 2'd2, 1'b1, 6'd63, 6'd63, 16'hFFFF, 24'd0,
                             11'd700));
    stimq.push_back(mk_row(10'd699));
    stimq.push_back(mk_row(10'd700));
    stimq.push_back(mk_row(10'd767));
    stimq.push_back(mk_setup(10'd5, 1'b1, 2'd0, 1'b1, 6'd5, 6'd9, 16'd12345, 24'hFFFFFF,
                             11'h7FF));
    stimq.push_back(mk_row(10'd767));
    stimq.push_back(mk_setup(10'd6, 1'b1, 2'd3, 1'b0, 6'd1, 6'd2, 16'd1, 24'd3, 11'd769));
    stimq.push_back(mk_row(10'd767));
    stimq.push_back(mk_setup(10'd7, 1'b0, 2'd0, 1'b0, 6'd3, 6'd4, 16'd40000, 24'd1,
                             11'd400));
    stimq.push_back(mk_row(10'd500));
    stimq.push_back(mk_setup(10'd8, 1'b0, 2'd3, 1'b1, 6'd10, 6'd20, 16'd32768, 24'd200000,
                             11'd767));
    stimq.push_back(mk_row(10'd767));
    stimq.push_back(mk_setup(10'd9, 1'b1, 2'd1, 1'b0, 6'd0, 6'd63, 16'd0, 24'd65536,
                             11'd768));
    stimq.push_back(mk_row(10'd767));
    send_items();

    set_player(22'h3FFFFF, 22'h3FFFFF);
    random_phase(275);
    set_player(22'($urandom), 22'($urandom));
    random_phase(275);
    set_player(22'd0, 22'h3FFFFF);
    random_phase(275);
    set_player(22'h3FFFFF, 22'd0);
    random_phase(275);

    while (texel_expq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (texel_expq.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, texel_expq.size());
    end
    $display("Sent %0d column set-ups and %0d row requests over five player positions;",
             setups_sent, rows_sent);
    $display("checked %0d texel results, %0d errors.", results_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", texel_expq.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
